/* rtl/tmsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmsl_pkg
// Shared types and constants for the six-thruster mixer with slew limit.
// ----------------------------------------------------------------------------
package tmsl_pkg;

  // thruster count and field widths
  localparam int NUM_THRUSTERS = 6;
  localparam int NUM_AXES      = 4;
  localparam int EFF_W         = 16;
  localparam int LIM_W         = 15;
  localparam int ACC_W         = 16;
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  // register map, as word index within the config space
  typedef enum logic [1:0] {
    REG_XY_LIMIT     = 2'd0,
    REG_ACCEL_LIMIT  = 2'd1,
    REG_FULL_FORWARD = 2'd2,
    REG_FULL_REVERSE = 2'd3
  } reg_idx_t;

  // reset values of the limit registers
  localparam logic [LIM_W-1:0]        XY_LIMIT_RST     = 15'd16384;
  localparam logic [ACC_W-1:0]        ACCEL_LIMIT_RST  = 16'd1638;
  localparam logic [LIM_W-1:0]        FULL_FORWARD_RST = 15'd16384;
  localparam logic signed [LIM_W-1:0] FULL_REVERSE_RST = -15'sd16384;

  // mixing coefficient: -1, 0 or +1
  typedef logic signed [1:0] coef_t;

  // per thruster: forward, strafe, yaw, vertical
  localparam coef_t MIX_COEF [NUM_THRUSTERS][NUM_AXES] = '{
    '{ 2'sd1,  2'sd1,  2'sd1,  2'sd0},
    '{ 2'sd1, -2'sd1, -2'sd1,  2'sd0},
    '{ 2'sd1, -2'sd1,  2'sd1,  2'sd0},
    '{ 2'sd1,  2'sd1, -2'sd1,  2'sd0},
    '{ 2'sd0,  2'sd0,  2'sd0,  2'sd1},
    '{ 2'sd0,  2'sd0,  2'sd0, -2'sd1}
  };

endpackage

/* rtl/thruster_mixer_slew_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thruster_mixer_slew_limiter_core
// Mixes forward, strafe, yaw and vertical efforts into six thruster efforts,
// clamps each stage, and slew-limits against the previous effort.
// ----------------------------------------------------------------------------
//
// channel  role     handshake                     payload
// -------  -------  ----------------------------  ---------------------------
// in_      slave    in_tvalid / in_tready         in_tdata: 4 efforts
// out_     master   out_tvalid / out_tready       out_tdata: 6 efforts,
//                                                 out_tuser: saturated
// cfg      APB      psel / penable / pwrite       4 limit registers
//
// one word per cycle sustained while out_tready holds; a result word passes
// through the input register, then the result register, and waits there
// while the output stalls. the previous-effort update (mix, clamp, slew,
// store) is written together with the result word.
// rst_n (synchronous) clears handshake state and previous efforts and loads
// the default limits. a stalled output holds its word while the input
// register can still take one more word.
// ----------------------------------------------------------------------------
module thruster_mixer_slew_limiter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // forward, strafe, yaw, vertical effort
  input  logic [63:0]                in_tdata,
  // result words
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // front_right_out, front_left_out, rear_right_out, rear_left_out,
  // vertical_right_out, vertical_left_out
  output logic [95:0]                out_tdata,
  // saturated
  output logic [0:0]                 out_tuser,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tmsl_pkg::CFG_AW-1:0] paddr,
  input  logic [tmsl_pkg::CFG_DW-1:0] pwdata,
  output logic [tmsl_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  localparam int NT = tmsl_pkg::NUM_THRUSTERS;
  localparam int EW = tmsl_pkg::EFF_W;

  // limit registers
  logic [tmsl_pkg::LIM_W-1:0]        xy_limit_r;
  logic [tmsl_pkg::ACC_W-1:0]        accel_limit_r;
  logic [tmsl_pkg::LIM_W-1:0]        full_forward_r;
  logic signed [tmsl_pkg::LIM_W-1:0] full_reverse_r;

  // pipeline registers
  logic                  in_valid_r;
  logic signed [EW-1:0]  eff_in_r [tmsl_pkg::NUM_AXES];
  logic                  out_valid_r;
  logic [95:0]           out_data_r;
  logic                  out_sat_r;
  logic signed [EW-1:0]  prev_r [NT];

  logic                  in_acc;
  logic                  adv;
  logic                  cfg_wr;
  tmsl_pkg::reg_idx_t    cfg_idx;

  logic signed [EW-1:0]  eff_nxt [NT];
  logic [NT-1:0]         sat_vec;
  logic [95:0]           out_data_nxt;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = tmsl_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xy_limit_r     <= tmsl_pkg::XY_LIMIT_RST;
      accel_limit_r  <= tmsl_pkg::ACCEL_LIMIT_RST;
      full_forward_r <= tmsl_pkg::FULL_FORWARD_RST;
      full_reverse_r <= tmsl_pkg::FULL_REVERSE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tmsl_pkg::REG_XY_LIMIT:     xy_limit_r     <= pwdata[14:0];
        tmsl_pkg::REG_ACCEL_LIMIT:  accel_limit_r  <= pwdata[15:0];
        tmsl_pkg::REG_FULL_FORWARD: full_forward_r <= pwdata[14:0];
        tmsl_pkg::REG_FULL_REVERSE: full_reverse_r <= $signed(pwdata[14:0]);
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      tmsl_pkg::REG_XY_LIMIT:     prdata = {17'd0, xy_limit_r};
      tmsl_pkg::REG_ACCEL_LIMIT:  prdata = {16'd0, accel_limit_r};
      tmsl_pkg::REG_FULL_FORWARD: prdata = {17'd0, full_forward_r};
      tmsl_pkg::REG_FULL_REVERSE: prdata = {{17{full_reverse_r[14]}}, full_reverse_r};
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // handshake: input register feeds result register
  // --------------------------------------------------------------------------
  assign adv       = in_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | adv;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int k = 0; k < tmsl_pkg::NUM_AXES; k++) begin
        eff_in_r[k] <= $signed(in_tdata[k*EW +: EW]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // per-thruster mix, clamp and slew
  // --------------------------------------------------------------------------

  // weight an effort by -1, 0 or +1
  function automatic logic signed [17:0] mix_term(tmsl_pkg::coef_t c,
                                                   logic signed [EW-1:0] e);
    logic signed [17:0] ext;
    ext = 18'(e);
    if (c > 0)
      return ext;
    else if (c < 0)
      return -ext;
    else
      return 18'sd0;
  endfunction

  for (genvar i = 0; i < NT; i++) begin : g_thr
    logic signed [17:0] fwd_t, str_t, yaw_t, vrt_t;
    logic signed [17:0] xy_sum, xy_pos, xy_neg, xy_c;
    logic signed [17:0] yaw_sum, ff_ext, fr_ext, yaw_c, vrt_c;
    logic signed [18:0] tot, prev_ext, acc_ext, lo, hi, slew, chk;
    logic               sat_xy, sat_yaw, sat_vrt;

    assign fwd_t = mix_term(tmsl_pkg::MIX_COEF[i][0], eff_in_r[0]);
    assign str_t = mix_term(tmsl_pkg::MIX_COEF[i][1], eff_in_r[1]);
    assign yaw_t = mix_term(tmsl_pkg::MIX_COEF[i][2], eff_in_r[2]);
    assign vrt_t = mix_term(tmsl_pkg::MIX_COEF[i][3], eff_in_r[3]);

    assign xy_pos = $signed({3'b000, xy_limit_r});
    assign xy_neg = -xy_pos;
    assign ff_ext = $signed({3'b000, full_forward_r});
    assign fr_ext = 18'(full_reverse_r);

    always_comb begin
      // forward plus strafe against the xy limit
      xy_sum = fwd_t + str_t;
      sat_xy = 1'b0;
      if (xy_sum > xy_pos) begin
        xy_c   = xy_pos;
        sat_xy = 1'b1;
      end else if (xy_sum < xy_neg) begin
        xy_c   = xy_neg;
        sat_xy = 1'b1;
      end else begin
        xy_c = xy_sum;
      end

      // add yaw, then full-thrust clamp, upper bound first
      yaw_sum = xy_c + yaw_t;
      sat_yaw = 1'b0;
      if (yaw_sum > ff_ext) begin
        yaw_c   = ff_ext;
        sat_yaw = 1'b1;
      end else if (yaw_sum < fr_ext) begin
        yaw_c   = fr_ext;
        sat_yaw = 1'b1;
      end else begin
        yaw_c = yaw_sum;
      end

      // vertical term gets the same clamp on its own
      sat_vrt = 1'b0;
      if (vrt_t > ff_ext) begin
        vrt_c   = ff_ext;
        sat_vrt = 1'b1;
      end else if (vrt_t < fr_ext) begin
        vrt_c   = fr_ext;
        sat_vrt = 1'b1;
      end else begin
        vrt_c = vrt_t;
      end

      // slew limit around the previous effort
      tot      = 19'(yaw_c) + 19'(vrt_c);
      prev_ext = 19'(prev_r[i]);
      acc_ext  = $signed({3'b000, accel_limit_r});
      lo       = prev_ext - acc_ext;
      hi       = prev_ext + acc_ext;
      slew     = tot;
      if (slew < lo)
        slew = lo;
      if (slew > hi)
        slew = hi;

      // no sign reversal in one step
      chk = slew;
      if ((chk < 0 && prev_ext > 0) || (chk > 0 && prev_ext < 0))
        chk = 19'sd0;

      // saturate to the output width
      if (chk > 19'sd32767)
        eff_nxt[i] = 16'sh7fff;
      else if (chk < -19'sd32768)
        eff_nxt[i] = 16'sh8000;
      else
        eff_nxt[i] = chk[15:0];

      sat_vec[i] = sat_xy | sat_yaw | sat_vrt;
    end

    assign out_data_nxt[i*EW +: EW] = eff_nxt[i];
  end

  // --------------------------------------------------------------------------
  // result register and previous-effort store
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < NT; i++) begin
          prev_r[i] <= eff_nxt[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_sat_r  <= |sat_vec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // a pending result always matches the stored previous efforts
  for (genvar i = 0; i < NT; i++) begin : g_chk
    a_prev_match: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (prev_r[i] == $signed(out_data_r[i*EW +: EW])))
      else $error("stored effort differs from pending result");

    a_no_reversal: assert property (@(posedge clk) disable iff (!rst_n)
      adv |=> !((prev_r[i] > 0 && $past(prev_r[i]) < 0) ||
                (prev_r[i] < 0 && $past(prev_r[i]) > 0)))
      else $error("thruster effort reversed sign in one step");
  end

  // a held input word is not dropped while the output stalls
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> in_valid_r)
    else $error("input word lost during output stall");

  // the previous effort of thruster 0 changes only when a word moves to the result register
  a_prev_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && $past(rst_n)) |=> (prev_r[0] == $past(prev_r[0])))
    else $error("previous effort changed without a word");

endmodule
